### hdl/svm_pkg.sv
// ============================================================================
// svm_pkg: shared types and constants for the stack machine execute unit
// Command codes, status codes, controller/datapath command and status structs.
// ============================================================================
package svm_pkg;

    localparam int unsigned DataW    = 32;
    localparam int unsigned IpW      = 16;
    localparam int unsigned CmdW     = 4;
    localparam int unsigned StatW    = 2;
    localparam int unsigned LimitW   = 11;
    localparam int unsigned ProgLenW = 17;
    localparam int unsigned AddrW    = 3;

    localparam logic [AddrW-1:0] RegStackLimit = 3'd0;
    localparam logic [AddrW-1:0] RegProgLength = 3'd4;

    typedef enum logic [CmdW-1:0] {
        CMD_PUSH = 4'd0,
        CMD_POP  = 4'd1,
        CMD_CALL = 4'd2,
        CMD_RET  = 4'd3,
        CMD_JMP  = 4'd4,
        CMD_JZ   = 4'd5,
        CMD_JPOS = 4'd6,
        CMD_JNEG = 4'd7,
        CMD_ADD  = 4'd8,
        CMD_SUB  = 4'd9,
        CMD_MUL  = 4'd10,
        CMD_DIV  = 4'd11
    } cmd_t;

    typedef enum logic [StatW-1:0] {
        ST_OK      = 2'd0,
        ST_STACK   = 2'd1,
        ST_ARITH   = 2'd2,
        ST_RETADDR = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item, issue stack read
        logic iter_start; // begin mul/div iteration
        logic iter_step;  // one iteration step
        logic finish;     // evaluate result, update state, fill output
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic iter_done;
        logic is_iter;    // mul or div
    } dp_stat_t;

endpackage

### hdl/svm_if.sv
// ============================================================================
// svm_if: valid/ready channel
// Carries one item of the execute unit's input or result channel.
// ============================================================================
interface svm_in_if;
    logic                    valid;
    logic                    ready;
    logic [3:0]              command;
    logic signed [31:0]      operand_a;
    logic signed [31:0]      operand_b;
    logic [15:0]             target;
    modport source (output valid, command, operand_a, operand_b, target, input ready);
    modport sink   (input valid, command, operand_a, operand_b, target, output ready);
endinterface

interface svm_out_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [15:0]             next_ip;
    logic signed [31:0]      popped_value;
    logic                    write_back;
    modport source (output valid, status, next_ip, popped_value, write_back, input ready);
    modport sink   (input valid, status, next_ip, popped_value, write_back, output ready);
endinterface

### hdl/svm_ram.sv
// ============================================================================
// svm_ram: generic single-port RAM
// Writes when we is set; registered read data, old contents during a write.
// ============================================================================
module svm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

### hdl/svm_ctrl.sv
// ============================================================================
// svm_ctrl: execute unit controller
// Sequences load, stack read, optional mul/div iteration and write-back.
// ============================================================================
module svm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  svm_pkg::dp_stat_t stat,
    output svm_pkg::dp_cmd_t  cmd
);
    import svm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_ITER = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // accept only when the output register is free
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (stat.is_iter)
                begin
                    cmd.iter_start = 1'b1;
                    state_next     = S_ITER;
                end
                else
                    state_next = S_DONE;
            end
            S_ITER:
            begin
                cmd.iter_step = 1'b1;
                if (stat.iter_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

### hdl/svm_dp.sv
// ============================================================================
// svm_dp: execute unit datapath
// Stack memory, pointers, shift-add multiplier, restoring divider, checks.
// ============================================================================
module svm_dp #(
    parameter int unsigned STACK_DEPTH   = 1024,
    parameter int unsigned PROGRAM_SPACE = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  svm_pkg::dp_cmd_t              cmd,
    output svm_pkg::dp_stat_t             stat,
    input  logic [3:0]                    in_command,
    input  logic signed [31:0]            in_a,
    input  logic signed [31:0]            in_b,
    input  logic [15:0]                   in_target,
    input  logic [svm_pkg::LimitW-1:0]    stack_limit,
    input  logic [svm_pkg::ProgLenW-1:0]  program_length,
    output logic [1:0]                    out_status,
    output logic [15:0]                   out_next_ip,
    output logic signed [31:0]            out_popped,
    output logic                          out_wb
);
    import svm_pkg::*;

    localparam int unsigned SAW = $clog2(STACK_DEPTH);
    localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned PLW = $clog2(PROGRAM_SPACE + 1);
    localparam int unsigned CW  = 6;

    // captured item
    logic [3:0]        op_reg;
    logic [31:0]       a_reg, b_reg;
    logic [15:0]       tgt_reg;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [15:0]       ip_reg, ip_next;

    // iteration unit: magnitudes, 64-bit accumulator, 33-bit remainder
    logic [31:0]       ma_reg, mb_reg;
    logic [63:0]       acc_reg;
    logic [31:0]       quo_reg;
    logic [32:0]       rem_reg;
    logic [CW-1:0]     cnt_reg;
    logic              neg_reg;

    logic [1:0]        st_reg;
    logic [15:0]       nip_reg;
    logic [31:0]       pop_reg;
    logic              wb_reg;

    // effective limits
    logic [SPW-1:0]    eff_limit;
    logic [PLW-1:0]    eff_plen;
    always_comb
    begin
        if ({{(32-LimitW){1'b0}}, stack_limit} > 32'(STACK_DEPTH))
            eff_limit = SPW'(STACK_DEPTH);
        else
            eff_limit = SPW'(stack_limit);
        if ({{(32-ProgLenW){1'b0}}, program_length} > 32'(PROGRAM_SPACE))
            eff_plen = PLW'(PROGRAM_SPACE);
        else
            eff_plen = PLW'(program_length);
    end

    // stack memory: read top at load, write at finish
    logic           ram_we;
    logic [SAW-1:0] ram_addr;
    logic [31:0]    ram_wdata, ram_rdata;
    logic [SPW-1:0] sp_dec;
    assign sp_dec = sp_reg - 1'b1;

    svm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign stat.is_iter   = (op_reg == CMD_MUL) || (op_reg == CMD_DIV);
    assign stat.iter_done = (cnt_reg == CW'(31));

    // finish evaluation
    logic          full, empty;
    logic [32:0]   sum;
    logic [63:0]   mag64;
    logic          ovf;
    logic [31:0]   res;
    logic [1:0]    st_c;
    logic [15:0]   nip_c;
    logic          push_c, pop_c;
    logic [31:0]   pushv;
    logic signed [31:0] top;
    logic [15:0]   ip_inc;

    assign full   = sp_reg >= eff_limit;
    assign empty  = sp_reg == '0;
    assign top    = ram_rdata;
    assign ip_inc = ip_reg + 16'd1;

    always_comb
    begin
        sum    = '0;
        mag64  = '0;
        ovf    = 1'b0;
        res    = '0;
        st_c   = ST_OK;
        nip_c  = ip_inc;
        push_c = 1'b0;
        pop_c  = 1'b0;
        pushv  = '0;
        unique case (op_reg)
            CMD_PUSH:
            begin
                if (full) st_c = ST_STACK;
                else begin push_c = 1'b1; pushv = a_reg; end
            end
            CMD_POP:
            begin
                if (empty) st_c = ST_STACK;
                else pop_c = 1'b1;
            end
            CMD_CALL:
            begin
                if (full) st_c = ST_STACK;
                else
                begin
                    push_c = 1'b1;
                    pushv  = 32'({1'b0, ip_reg} + 17'd1);
                    nip_c  = tgt_reg;
                end
            end
            CMD_RET:
            begin
                if (empty) st_c = ST_STACK;
                else if (top[31] || {1'b0, top} >= 33'(eff_plen)) st_c = ST_RETADDR;
                else begin pop_c = 1'b1; nip_c = top[15:0]; end
            end
            CMD_JMP: nip_c = tgt_reg;
            CMD_JZ, CMD_JPOS, CMD_JNEG:
            begin
                if (empty) st_c = ST_STACK;
                else
                begin
                    pop_c = 1'b1;
                    if ((op_reg == CMD_JZ && top == 0) ||
                        (op_reg == CMD_JPOS && top > 0) ||
                        (op_reg == CMD_JNEG && top < 0))
                        nip_c = tgt_reg;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
            begin
                if (op_reg == CMD_ADD)
                begin
                    sum = {a_reg[31], a_reg} + {b_reg[31], b_reg};
                    ovf = sum[32] != sum[31];
                    res = sum[31:0];
                end
                else if (op_reg == CMD_SUB)
                begin
                    sum = {a_reg[31], a_reg} - {b_reg[31], b_reg};
                    ovf = sum[32] != sum[31];
                    res = sum[31:0];
                end
                else
                begin
                    if (op_reg == CMD_MUL) mag64 = acc_reg;
                    else mag64 = {32'd0, quo_reg};
                    res = neg_reg ? (32'd0 - mag64[31:0]) : mag64[31:0];
                    if (neg_reg) ovf = (mag64 > 64'h8000_0000);
                    else ovf = (mag64 > 64'h7FFF_FFFF);
                    if (op_reg == CMD_DIV && b_reg == '0) ovf = 1'b1;
                end
                if (ovf) st_c = ST_ARITH;
                else if (full) st_c = ST_STACK;
                else begin push_c = 1'b1; pushv = res; end
            end
            default: ;
        endcase
        if (st_c != ST_OK)
            nip_c = ip_reg;
    end

    always_comb
    begin
        ram_we    = cmd.finish && push_c;
        ram_wdata = pushv;
        if (cmd.finish) ram_addr = sp_reg[SAW-1:0];
        else            ram_addr = sp_dec[SAW-1:0];
    end

    always_comb
    begin
        sp_next = sp_reg;
        ip_next = ip_reg;
        if (cmd.finish)
        begin
            if (push_c) sp_next = sp_reg + 1'b1;
            else if (pop_c) sp_next = sp_dec;
            ip_next = nip_c;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg  <= '0;
            ip_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
            ip_reg <= ip_next;
            if (cmd.iter_start) cnt_reg <= '0;
            else if (cmd.iter_step) cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // item capture, iteration and output register
    logic [32:0] trial;
    assign trial = {rem_reg[31:0], ma_reg[31]} - {1'b0, mb_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_command;
            a_reg   <= in_a;
            b_reg   <= in_b;
            tgt_reg <= in_target;
        end
        if (cmd.iter_start)
        begin
            ma_reg  <= a_reg[31] ? (32'd0 - a_reg) : a_reg;
            mb_reg  <= b_reg[31] ? (32'd0 - b_reg) : b_reg;
            neg_reg <= a_reg[31] ^ b_reg[31];
            acc_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (cmd.iter_step)
        begin
            if (op_reg == CMD_MUL)
            begin
                // MSB-first shift-add
                acc_reg <= (acc_reg << 1) + (ma_reg[31] ? {32'd0, mb_reg} : 64'd0);
                ma_reg  <= ma_reg << 1;
            end
            else
            begin
                // restoring division, one quotient bit per step
                if (!trial[32])
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[31:0], ma_reg[31]};
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                ma_reg <= ma_reg << 1;
            end
        end
        if (cmd.finish)
        begin
            st_reg  <= st_c;
            nip_reg <= nip_c;
            pop_reg <= pop_c && (op_reg == CMD_POP) ? ram_rdata : 32'd0;
            wb_reg  <= pop_c && (op_reg == CMD_POP);
        end
    end

    assign out_status  = st_reg;
    assign out_next_ip = nip_reg;
    assign out_popped  = pop_reg;
    assign out_wb      = wb_reg;
endmodule

### hdl/stack_vm_execute_unit.sv
// ============================================================================
// stack_vm_execute_unit: stack machine execute unit
// Executes one push/pop/call/ret/jump/arith instruction per item.
// ============================================================================
// Channel   Dir  Handshake    Payload
// in_ch     in   valid/ready  command, operand_a, operand_b, target
// out_ch    out  valid/ready  status, next_ip, popped_value, write_back
// apb       in   psel/penable stack_limit @0x0, program_length @0x4
//
// An item passes through load, stack read and finish before its result is
// registered; mul and div add 32 steps of the shift-add / restoring-divide unit.
// The top-of-stack read is issued at load, its data ready in the read state.
// A new item is taken once the previous result has left the output register.
// Reset clears pointers and control; stack contents stay undefined.
// ============================================================================
module stack_vm_execute_unit #(
    parameter int unsigned STACK_DEPTH   = 1024,
    parameter int unsigned PROGRAM_SPACE = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    svm_in_if.sink      in_ch,
    svm_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import svm_pkg::*;

    logic [LimitW-1:0]   limit_reg;
    logic [ProgLenW-1:0] plen_reg;
    dp_cmd_t             cmd;
    dp_stat_t            stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LimitW'(1024);
            plen_reg  <= ProgLenW'(65536);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == RegStackLimit) limit_reg <= pwdata[LimitW-1:0];
            else if (paddr == RegProgLength) plen_reg <= pwdata[ProgLenW-1:0];
        end
    end

    always_comb
    begin
        if (paddr == RegStackLimit) prdata = {{(32-LimitW){1'b0}}, limit_reg};
        else if (paddr == RegProgLength) prdata = {{(32-ProgLenW){1'b0}}, plen_reg};
        else prdata = '0;
    end

    svm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    svm_dp #(.STACK_DEPTH(STACK_DEPTH), .PROGRAM_SPACE(PROGRAM_SPACE)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_command     (in_ch.command),
        .in_a           (in_ch.operand_a),
        .in_b           (in_ch.operand_b),
        .in_target      (in_ch.target),
        .stack_limit    (limit_reg),
        .program_length (plen_reg),
        .out_status     (out_ch.status),
        .out_next_ip    (out_ch.next_ip),
        .out_popped     (out_ch.popped_value),
        .out_wb         (out_ch.write_back)
    );
endmodule

### sim/tb_stack_vm_execute_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_stack_vm_execute_unit: self-checking bench for the stack machine unit
// Drives instruction items through the input channel and the APB port. A
// shadow copy of the stack, stack pointer and instruction pointer predicts
// each result, which is compared field by field on the result channel.
// ============================================================================
module tb_stack_vm_execute_unit;
    import svm_pkg::*;

    localparam int  Depth     = 1024;
    localparam int  ProgSpace = 65536;
    localparam int  IdleLimit = 4000;
    localparam int  HoldLen   = 300;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] next_ip;
        logic [31:0] popped_value;
        logic        write_back;
    } outcome_t;

    // Shadow machine state plus the queue of outcomes still to arrive
    class exec_tracker;
        logic [31:0] stack_mem [Depth];
        int          sp;
        logic [15:0] ip;
        int          stack_limit;
        int          prog_length;
        outcome_t    pending[$];
        int          mismatches;
        int          status_seen[4];
        int          writebacks;

        function void init();
            sp = 0;
            ip = '0;
            stack_limit = 1024;
            prog_length = 65536;
            mismatches = 0;
            writebacks = 0;
            for (int i = 0; i < 4; i++)
                status_seen[i] = 0;
        endfunction

        function void configure(logic [AddrW-1:0] addr, logic [31:0] data);
            if (addr == RegStackLimit)
                stack_limit = int'(data & 32'h7FF);
            else if (addr == RegProgLength)
                prog_length = int'(data & 32'h1FFFF);
        endfunction

        function int eff_limit();
            return (stack_limit < Depth) ? stack_limit : Depth;
        endfunction

        function longint top_entry();
            logic signed [31:0] v;
            v = stack_mem[(sp - 1) % Depth];
            return longint'(v);
        endfunction

        function void push_word(longint v);
            stack_mem[sp % Depth] = v[31:0];
            sp++;
        endfunction

        function void note_instruction(logic [3:0] cmd, logic signed [31:0] a,
                                       logic signed [31:0] b, logic [15:0] tgt);
            outcome_t o;
            longint   r;
            longint   t;
            bit       arith;
            bit       take;
            int       plen;
            o.status = ST_OK;
            o.next_ip = ip + 16'd1;
            o.popped_value = '0;
            o.write_back = 1'b0;
            arith = 0;
            r = 0;
            plen = (prog_length < ProgSpace) ? prog_length : ProgSpace;
            case (cmd)
                CMD_PUSH:
                    if (sp >= eff_limit()) o.status = ST_STACK;
                    else push_word(longint'(a));
                CMD_POP:
                    if (sp == 0) o.status = ST_STACK;
                    else
                    begin
                        o.popped_value = stack_mem[(sp - 1) % Depth];
                        o.write_back = 1'b1;
                        sp--;
                    end
                CMD_CALL:
                    if (sp >= eff_limit()) o.status = ST_STACK;
                    else
                    begin
                        push_word(longint'(ip) + 1);
                        o.next_ip = tgt;
                    end
                CMD_RET:
                    if (sp == 0) o.status = ST_STACK;
                    else
                    begin
                        t = top_entry();
                        if (t < 0 || t >= plen) o.status = ST_RETADDR;
                        else
                        begin
                            sp--;
                            o.next_ip = t[15:0];
                        end
                    end
                CMD_JMP:
                    o.next_ip = tgt;
                CMD_JZ, CMD_JPOS, CMD_JNEG:
                    if (sp == 0) o.status = ST_STACK;
                    else
                    begin
                        t = top_entry();
                        take = (cmd == CMD_JZ) ? (t == 0) :
                               (cmd == CMD_JPOS) ? (t > 0) : (t < 0);
                        sp--;
                        if (take) o.next_ip = tgt;
                    end
                CMD_ADD:
                begin
                    r = longint'(a) + longint'(b);
                    arith = 1;
                end
                CMD_SUB:
                begin
                    r = longint'(a) - longint'(b);
                    arith = 1;
                end
                CMD_MUL:
                begin
                    r = longint'(a) * longint'(b);
                    arith = 1;
                end
                CMD_DIV:
                    if (b == 0) o.status = ST_ARITH;
                    else
                    begin
                        r = longint'(a) / longint'(b);
                        arith = 1;
                    end
                default: ;
            endcase
            // range check comes ahead of the full-stack check
            if (arith)
            begin
                if (r > 64'sd2147483647 || r < -64'sd2147483648) o.status = ST_ARITH;
                else if (sp >= eff_limit()) o.status = ST_STACK;
                else push_word(r);
            end
            if (o.status != ST_OK)
                o.next_ip = ip;
            ip = o.next_ip;
            pending.push_back(o);
        endfunction

        function void check_outcome(logic [1:0] st, logic [15:0] nip,
                                    logic [31:0] pv, logic wb);
            outcome_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: status=%0d next_ip=%0h", st, nip);
                mismatches++;
                return;
            end
            e = pending.pop_front();
            status_seen[e.status]++;
            if (e.write_back) writebacks++;
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                mismatches++;
            end
            if (nip !== e.next_ip)
            begin
                $error("next_ip: expected %0h, got %0h", e.next_ip, nip);
                mismatches++;
            end
            if (pv !== e.popped_value)
            begin
                $error("popped_value: expected %0h, got %0h", e.popped_value, pv);
                mismatches++;
            end
            if (wb !== e.write_back)
            begin
                $error("write_back: expected %0b, got %0b", e.write_back, wb);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    svm_in_if  in_if ();
    svm_out_if out_if ();

    stack_vm_execute_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    exec_tracker tracker;
    bit          eager;
    bit          hold_req;
    int          items_sent;
    int          idle_cycles;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Result channel: random backpressure, plus one long hold on request
    initial
    begin
        int stall;
        stall = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                out_if.ready <= 1'b0;
                repeat (HoldLen) @(negedge clk);
            end
            else if (eager)
                out_if.ready <= 1'b1;
            else if (stall > 0)
            begin
                out_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                stall = pick_gap();
                out_if.ready <= (stall == 0);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && out_if.valid && out_if.ready)
            tracker.check_outcome(out_if.status, out_if.next_ip,
                                  out_if.popped_value, out_if.write_back);

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: case ($urandom_range(0, 4))
                   0: return 32'sh7FFFFFFF;
                   1: return 32'sh80000000;
                   2: return -32'sd1;
                   3: return 32'sd1;
                   default: return 32'sd0;
               endcase
            1, 2: return int'($urandom_range(0, 200)) - 100;
            3: return int'($urandom_range(0, 131071)) - 65536;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [3:0] cmd, logic signed [31:0] a,
                             logic signed [31:0] b, logic [15:0] tgt);
        int gap;
        gap = eager ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_if.valid     <= 1'b1;
        in_if.command   <= cmd;
        in_if.operand_a <= a;
        in_if.operand_b <= b;
        in_if.target    <= tgt;
        do @(posedge clk); while (!in_if.ready);
        tracker.note_instruction(cmd, a, b, tgt);
        items_sent++;
    endtask

    // stop offering and wait until every outcome has come back
    task automatic drain();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.configure(addr, data);
    endtask

    task automatic random_item();
        int          r;
        logic [3:0]  cmd;
        logic signed [31:0] a;
        logic signed [31:0] b;
        int          plen;
        r = $urandom_range(0, 99);
        plen = (tracker.prog_length < ProgSpace) ? tracker.prog_length : ProgSpace;
        a = pick_word();
        b = pick_word();
        if      (r < 18) cmd = CMD_PUSH;
        else if (r < 25) cmd = CMD_CALL;
        else if (r < 30) cmd = CMD_ADD;
        else if (r < 35) cmd = CMD_SUB;
        else if (r < 40) cmd = CMD_MUL;
        else if (r < 45) cmd = CMD_DIV;
        else if (r < 57) cmd = CMD_POP;
        else if (r < 69) cmd = CMD_RET;
        else if (r < 76) cmd = CMD_JZ;
        else if (r < 83) cmd = CMD_JPOS;
        else if (r < 90) cmd = CMD_JNEG;
        else if (r < 95) cmd = CMD_JMP;
        else             cmd = 4'($urandom_range(12, 15));
        // plausible return addresses so that ret mostly succeeds
        if (cmd == CMD_PUSH && $urandom_range(0, 2) == 0)
            a = (plen > 0) ? $urandom_range(0, plen - 1) : 0;
        if (cmd == CMD_MUL && $urandom_range(0, 1) == 0)
        begin
            a = int'($urandom_range(0, 131071)) - 65536;
            b = int'($urandom_range(0, 65535)) - 32768;
        end
        if (cmd == CMD_DIV && $urandom_range(0, 9) == 0)
            b = 32'sd0;
        send_item(cmd, a, b, 16'($urandom_range(0, 65535)));
    endtask

    task automatic directed_items();
        send_item(CMD_POP,  0, 0, 16'h0000);
        send_item(CMD_RET,  0, 0, 16'h0000);
        send_item(CMD_JZ,   0, 0, 16'h0100);
        send_item(CMD_PUSH, 32'sh7FFFFFFF, 0, 16'h0000);
        send_item(CMD_PUSH, 32'sh80000000, 0, 16'h0000);
        send_item(CMD_ADD,  32'sh7FFFFFFF, 32'sd1, 16'h0000);
        send_item(CMD_SUB,  32'sh80000000, 32'sd1, 16'h0000);
        send_item(CMD_ADD,  32'sh80000000, 32'sh7FFFFFFF, 16'h0000);
        send_item(CMD_MUL,  32'sd65536, 32'sd32768, 16'h0000);
        send_item(CMD_MUL,  -32'sd65536, 32'sd32768, 16'h0000);
        send_item(CMD_MUL,  32'sh80000000, -32'sd1, 16'h0000);
        send_item(CMD_DIV,  32'sd5, 32'sd0, 16'h0000);
        send_item(CMD_DIV,  32'sh80000000, -32'sd1, 16'h0000);
        send_item(CMD_DIV,  -32'sd7, 32'sd2, 16'h0000);
        send_item(CMD_JNEG, 0, 0, 16'hFFFF);
        send_item(CMD_PUSH, 32'sd0, 0, 16'h0000);
        send_item(CMD_JMP,  0, 0, 16'hFFFF);
        // call at the top of the program pushes an address one past it
        send_item(CMD_CALL, 0, 0, 16'h000A);
        send_item(CMD_RET,  0, 0, 16'h0000);
        send_item(CMD_POP,  0, 0, 16'h0000);
        send_item(CMD_CALL, 0, 0, 16'h1234);
        send_item(CMD_RET,  0, 0, 16'h0000);
        send_item(CMD_JZ,   0, 0, 16'h0042);
        send_item(CMD_JPOS, 0, 0, 16'h0043);
        send_item(4'd13,    32'sh55555555, 32'shAAAAAAAA, 16'hFFFF);
    endtask

    // main sequence: reset, directed items, then phases of random items
    initial
    begin
        logic [31:0] limits [7];
        logic [31:0] lengths [7];
        limits  = '{1024, 0, 3, 2047, 16, 600, 1024};
        lengths = '{65536, 1, 40, 131071, 0, 1000, 65536};
        tracker = new();
        tracker.init();
        eager = 0;
        hold_req = 0;
        items_sent = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.command = '0;
        in_if.operand_a = '0;
        in_if.operand_b = '0;
        in_if.target = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_items();
        for (int ph = 0; ph < 7; ph++)
        begin
            drain();
            write_reg(RegStackLimit, limits[ph]);
            write_reg(RegProgLength, lengths[ph]);
            eager = (ph == 5);
            for (int n = 0; n < 260; n++)
            begin
                if (ph == 2 && n == 100)
                    hold_req = 1;
                if (ph == 3 && n == 130)
                    drain();
                random_item();
            end
        end
        drain();
        repeat (50) @(posedge clk);

        $display("Ran %0d instructions over 7 limit settings; %0d pops wrote back.",
                 items_sent, tracker.writebacks);
        $display("Status mix: ok %0d, stack %0d, arith %0d, bad return %0d.",
                 tracker.status_seen[0], tracker.status_seen[1],
                 tracker.status_seen[2], tracker.status_seen[3]);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
